// ----- design/b64d_pkg.sv -----
package b64d_pkg;

    // queue between the classifier and the decode engine
    localparam int QUEUE_DEPTH = 2;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int STATUS_W = 3;
    localparam int USER_W   = 1 + STATUS_W;

    // final status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PAD   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NONCANON  = 3'd4;

    // special alphabet characters
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_PAD,
        KIND_BAD
    } sym_kind_t;

    typedef struct packed {
        logic                is_last;
        sym_kind_t           kind;
        logic [SEXTET_W-1:0] value;
    } sym_t;

    // maps one raw character to its kind and 6-bit value
    function automatic sym_t classify(input logic [CHAR_W-1:0] ch, input logic last);
        sym_t              s;
        logic [CHAR_W-1:0] diff;
        s.is_last = last;
        s.kind    = KIND_BAD;
        s.value   = '0;
        diff      = '0;
        if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z)
        begin
            diff    = ch - CHAR_UP_A;
            s.kind  = KIND_DATA;
            s.value = diff[SEXTET_W-1:0];
        end
        else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z)
        begin
            diff    = ch - CHAR_LO_A + 8'd26;
            s.kind  = KIND_DATA;
            s.value = diff[SEXTET_W-1:0];
        end
        else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            diff    = ch - CHAR_ZERO + 8'd52;
            s.kind  = KIND_DATA;
            s.value = diff[SEXTET_W-1:0];
        end
        else if (ch == CHAR_PLUS)
        begin
            s.kind  = KIND_DATA;
            s.value = SEXTET_PLUS;
        end
        else if (ch == CHAR_SLASH)
        begin
            s.kind  = KIND_DATA;
            s.value = SEXTET_SLASH;
        end
        else if (ch == CHAR_PAD)
        begin
            s.kind  = KIND_PAD;
        end
        return s;
    endfunction

endpackage

// ----- design/b64d_front.sv -----
module b64d_front
(
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // character
    input  logic                       s_tlast,   // is_last
    output logic                       push,
    output b64d_pkg::sym_t             push_sym,
    input  logic                       queue_full
);

    // classify on the way in so the back end sees only kind and sextet
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;
    assign push_sym = b64d_pkg::classify(s_tdata, s_tlast);

endmodule

// ----- design/b64d_queue.sv -----
module b64d_queue
#(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::sym_t push_sym,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output b64d_pkg::sym_t pop_sym
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::sym_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_sym   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_sym;
        end
    end

endmodule

// ----- design/b64d_back.sv -----
module b64d_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   not_empty,
    input  b64d_pkg::sym_t         pop_sym,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // data_byte
    output logic                   m_tlast,   // end_of_string
    output logic [3:0]             m_tuser    // byte_valid, status[2:0]
);

    localparam logic [1:0] SCAN_NONE = 2'd0;
    localparam logic [1:0] SCAN_PAD  = 2'd1;
    localparam logic [1:0] SCAN_BAD  = 2'd2;

    logic [11:0] acc_reg,  acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [1:0]  len_reg,  len_next;
    logic [1:0]  run_reg,  run_next;
    logic [1:0]  err_reg,  err_next;
    logic [5:0]  ldv_reg,  ldv_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg,  out_data_next;
    logic        out_last_reg,  out_last_next;
    logic [3:0]  out_user_reg,  out_user_next;

    logic        have_byte;
    logic [7:0]  byte_val;
    logic [3:0]  pend_sum;
    logic [1:0]  rem;
    logic [2:0]  status;

    assign pop      = not_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // state update for one symbol
    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        len_next  = len_reg + 2'd1;
        run_next  = run_reg;
        err_next  = err_reg;
        ldv_next  = ldv_reg;
        have_byte = 1'b0;
        byte_val  = '0;
        pend_sum  = {1'b0, pend_reg} + 4'd6;
        unique case (pop_sym.kind)
            b64d_pkg::KIND_PAD:
            begin
                if (run_reg != 2'd3)
                begin
                    run_next = run_reg + 2'd1;
                end
            end
            b64d_pkg::KIND_DATA:
            begin
                if (run_reg != 2'd0 && err_reg == SCAN_NONE)
                begin
                    err_next = SCAN_PAD;
                end
                run_next = '0;
                ldv_next = pop_sym.value;
                acc_next = {acc_reg[5:0], pop_sym.value};
                if (pend_sum >= 4'd8)
                begin
                    pend_next = 3'(pend_sum - 4'd8);
                    have_byte = 1'b1;
                    // remaining pending bits sit below the completed byte
                    case (pend_next)
                        3'd2:    byte_val = acc_next[9:2];
                        3'd4:    byte_val = acc_next[11:4];
                        default: byte_val = acc_next[7:0];
                    endcase
                end
                else
                begin
                    pend_next = pend_sum[2:0];
                end
            end
            default:
            begin
                // bad character, an earlier pad run still counts first
                if (run_reg != 2'd0 && err_reg == SCAN_NONE)
                begin
                    err_next = SCAN_PAD;
                end
                else if (err_reg == SCAN_NONE)
                begin
                    err_next = SCAN_BAD;
                end
                run_next = '0;
            end
        endcase
    end

    // end-of-string verdict, structural checks ahead of scan errors
    always_comb
    begin
        rem = len_next - run_next;
        if (run_next == 2'd3)
        begin
            status = b64d_pkg::STATUS_BAD_PAD;
        end
        else if (run_next != 2'd0 && len_next != 2'd0)
        begin
            status = b64d_pkg::STATUS_BAD_PAD;
        end
        else if (rem == 2'd1)
        begin
            status = b64d_pkg::STATUS_BAD_LEN;
        end
        else if ((run_next == 2'd1 && rem != 2'd3) || (run_next == 2'd2 && rem != 2'd2))
        begin
            status = b64d_pkg::STATUS_BAD_PAD;
        end
        else if (err_next == SCAN_PAD)
        begin
            status = b64d_pkg::STATUS_BAD_PAD;
        end
        else if (err_next == SCAN_BAD)
        begin
            status = b64d_pkg::STATUS_BAD_CHAR;
        end
        else if ((rem == 2'd2 && ldv_next[3:0] != 4'd0) ||
                 (rem == 2'd3 && ldv_next[1:0] != 2'd0))
        begin
            status = b64d_pkg::STATUS_NONCANON;
        end
        else
        begin
            status = b64d_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop && (have_byte || pop_sym.is_last))
        begin
            out_valid_next = 1'b1;
            out_data_next  = byte_val;
            out_last_next  = pop_sym.is_last;
            out_user_next  = {pop_sym.is_last ? status : b64d_pkg::STATUS_OK, have_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            len_reg       <= '0;
            run_reg       <= '0;
            err_reg       <= SCAN_NONE;
            ldv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (pop_sym.is_last)
                begin
                    // next word starts a fresh string
                    acc_reg  <= '0;
                    pend_reg <= '0;
                    len_reg  <= '0;
                    run_reg  <= '0;
                    err_reg  <= SCAN_NONE;
                    ldv_reg  <= '0;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    pend_reg <= pend_next;
                    len_reg  <= len_next;
                    run_reg  <= run_next;
                    err_reg  <= err_next;
                    ldv_reg  <= ldv_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

endmodule

// ----- design/strict_base64_stream_decoder.sv -----
// strict base64 decoder: one character enters per word on the slave side, with tlast on the
// final character of a string, and the block sustains one word per clock while m_tready is
// high. a word leaves the master side when a byte completes (tuser bit 0 set, byte in tdata)
// or on the last character (tlast set, final status in tuser bits 3:1: 0 ok, 1 bad padding,
// 2 bad length, 3 bad character, 4 noncanonical trailing bits); a word can carry both.
// characters that complete no byte and are not last produce nothing. bytes are sent before the
// string is checked, so the consumer must drop the bytes of a string whose status is nonzero.
// internally a classifier feeds a short queue (QUEUE_DEPTH words) that a decode engine drains
// into an output register, every word going through both; either side may stall without loss

module strict_base64_stream_decoder
#(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // character[7:0]
    input  logic       s_tlast,    // is_last

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // data_byte[7:0]
    output logic       m_tlast,    // end_of_string
    output logic [3:0] m_tuser     // byte_valid, status[2:0]
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_not_empty;
    b64d_pkg::sym_t push_sym;
    b64d_pkg::sym_t pop_sym;

    // classifier, takes a word whenever the queue has room
    b64d_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_sym   (push_sym),
        .queue_full (queue_full)
    );

    // decouples input acceptance from output back-pressure
    b64d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_sym  (push_sym),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_sym   (pop_sym)
    );

    // bit accumulator, validation state and output register
    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (queue_not_empty),
        .pop_sym   (pop_sym),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
